@@ design/bsc_pkg.sv @@
// Shared types, constants and helper functions for the barometric compensation pipeline.
// No dependencies. Used by bsc_cal and baro_sensor_compensation.
package bsc_pkg;

  localparam int unsigned Lat = 20;
  localparam logic [63:0] CoefBias = 64'd16384;

  typedef enum logic [1:0] {
    CfgLow  = 2'd0,
    CfgMid  = 2'd1,
    CfgHigh = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } coef_t;

  function automatic logic [63:0] sx8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] zx16(logic [15:0] v);
    return {48'd0, v};
  endfunction

  // signed divide by 2^sh, rounding toward zero
  function automatic logic [63:0] sdiv(logic [63:0] v, logic [5:0] sh);
    logic [63:0] bias;
    logic [63:0] t;
    bias = v[63] ? ((64'd1 << sh) - 64'd1) : 64'd0;
    t = v + bias;
    return $unsigned($signed(t) >>> sh);
  endfunction

endpackage

@@ design/bsc_cal.sv @@
// Calibration register file and coefficient decode.
// Depends on bsc_pkg.
module bsc_cal (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i,
  output bsc_pkg::coef_t      coef_o
);

  logic [63:0] cal_low_q, cal_mid_q;
  logic [39:0] cal_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_mid_q  <= '0;
      cal_high_q <= '0;
    end else if (cfg_we_i) begin
      case (bsc_pkg::cfg_idx_e'(cfg_idx_i))
        bsc_pkg::CfgLow:  cal_low_q  <= cfg_wdata_i;
        bsc_pkg::CfgMid:  cal_mid_q  <= cfg_wdata_i;
        bsc_pkg::CfgHigh: cal_high_q <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  assign coef_o.t1  = cal_low_q[15:0];
  assign coef_o.t2  = cal_low_q[31:16];
  assign coef_o.t3  = cal_low_q[39:32];
  assign coef_o.p1  = cal_low_q[55:40];
  assign coef_o.p2  = {cal_mid_q[7:0], cal_low_q[63:56]};
  assign coef_o.p3  = cal_mid_q[15:8];
  assign coef_o.p4  = cal_mid_q[23:16];
  assign coef_o.p5  = cal_mid_q[39:24];
  assign coef_o.p6  = cal_mid_q[55:40];
  assign coef_o.p7  = cal_mid_q[63:56];
  assign coef_o.p8  = cal_high_q[7:0];
  assign coef_o.p9  = cal_high_q[23:8];
  assign coef_o.p10 = cal_high_q[31:24];
  assign coef_o.p11 = cal_high_q[39:32];

endmodule

@@ design/bsc_mul64.sv @@
// Two-stage wrapping 64x64 multiplier (low 64 bits) built from 32x32 partial products.
// No dependencies.
module bsc_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] pll_q;
  logic [31:0] phl_q, plh_q;
  logic [63:0] p_q;
  logic [63:0] phl_full, plh_full;

  assign phl_full = a_i[63:32] * b_i[31:0];
  assign plh_full = a_i[31:0] * b_i[63:32];

  always_ff @(posedge clk_i) begin
    pll_q <= a_i[31:0] * b_i[31:0];
    phl_q <= phl_full[31:0];
    plh_q <= plh_full[31:0];
    p_q   <= pll_q + {phl_q + plh_q, 32'd0};
  end

  assign p_o = p_q;

endmodule

@@ design/baro_sensor_compensation.sv @@
// Barometric sensor compensation: 64-bit integer temperature and pressure polynomial.
// One word accepted every cycle; busy stays low.
// Six multiply levels, each a bsc_mul64 followed by one add stage, lie between the entry stage and the output register.
// rst_ni clears the calibration registers and the valid chain; no word is in flight after it.
// The receiver cannot stall: each result shows on the ports for one cycle with done_o.
// Depends on bsc_pkg, bsc_cal, bsc_mul64.
module baro_sensor_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic [23:0]        raw_temperature_i,
  input  logic [23:0]        raw_pressure_i,
  output logic               done_o,
  output logic signed [23:0] temperature_centideg_o,
  output logic [31:0]        pressure_centipascal_o,
  output logic               out_of_range_o
);

  bsc_pkg::coef_t coef;
  logic [bsc_pkg::Lat-1:0] vld_q;

  bsc_cal u_cal (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[bsc_pkg::Lat-2:0], start & ~busy};
    end
  end

  // entry stage
  logic [63:0] d1_q;
  logic [23:0] rp0_q;

  always_ff @(posedge clk_i) begin
    d1_q  <= {40'd0, raw_temperature_i} - (bsc_pkg::zx16(coef.t1) << 8);
    rp0_q <= raw_pressure_i;
  end

  // level A: d2, d3, rp^2
  logic [63:0] ma0, ma1, ma2, rp0_w;
  logic [23:0] rpa1_q, rpa2_q, rpa_q;
  logic [63:0] d2a_q, d3a_q, r6a_q;

  assign rp0_w = {40'd0, rp0_q};
  bsc_mul64 u_ma0 (.clk_i(clk_i), .a_i(bsc_pkg::zx16(coef.t2)), .b_i(d1_q), .p_o(ma0));
  bsc_mul64 u_ma1 (.clk_i(clk_i), .a_i(d1_q), .b_i(d1_q), .p_o(ma1));
  bsc_mul64 u_ma2 (.clk_i(clk_i), .a_i(rp0_w), .b_i(rp0_w), .p_o(ma2));

  always_ff @(posedge clk_i) begin
    rpa1_q <= rp0_q;
    rpa2_q <= rpa1_q;
    rpa_q  <= rpa2_q;
    d2a_q  <= ma0;
    d3a_q  <= ma1;
    r6a_q  <= ma2;
  end

  // level B: d4, p11*r6, linearised temperature
  logic [63:0] mb0, mb1;
  logic [63:0] d2b1_q, d2b2_q;
  logic [23:0] rpb1_q, rpb2_q, rpb_q;
  logic [63:0] tlin_q, r2b_q;

  bsc_mul64 u_mb0 (.clk_i(clk_i), .a_i(d3a_q), .b_i(bsc_pkg::sx8(coef.t3)), .p_o(mb0));
  bsc_mul64 u_mb1 (.clk_i(clk_i), .a_i(bsc_pkg::sx8(coef.p11)), .b_i(r6a_q), .p_o(mb1));

  always_ff @(posedge clk_i) begin
    d2b1_q <= d2a_q;
    d2b2_q <= d2b1_q;
    rpb1_q <= rpa_q;
    rpb2_q <= rpb1_q;
    rpb_q  <= rpb2_q;
    tlin_q <= bsc_pkg::sdiv((d2b2_q << 18) + mb0, 6'd32);
    r2b_q  <= bsc_pkg::sdiv(mb1, 6'd16);
  end

  // level C: terms linear and quadratic in tlin, r2*rp, temperature output
  logic [63:0] mc0, mc1, mc2, mc3, mc4, rpb_w;
  logic [63:0] tlc1_q, tlc2_q, tlc_q;
  logic [23:0] rpc1_q, rpc2_q, rpc_q;
  logic [63:0] q1c_q, q2c_q, q6c_q, q5sc_q, r3c_q, r3bc_q;
  logic [63:0] ct;
  logic [23:0] tmpc_q;
  logic        tflc_q;

  assign rpb_w = {40'd0, rpb_q};
  bsc_mul64 u_mc0 (.clk_i(clk_i), .a_i(tlin_q), .b_i(tlin_q), .p_o(mc0));
  bsc_mul64 u_mc1 (.clk_i(clk_i), .a_i(bsc_pkg::zx16(coef.p6)), .b_i(tlin_q), .p_o(mc1));
  bsc_mul64 u_mc2 (.clk_i(clk_i), .a_i(bsc_pkg::sx16(coef.p2) - bsc_pkg::CoefBias),
                   .b_i(tlin_q), .p_o(mc2));
  bsc_mul64 u_mc3 (.clk_i(clk_i), .a_i(bsc_pkg::sx8(coef.p10)), .b_i(tlin_q), .p_o(mc3));
  bsc_mul64 u_mc4 (.clk_i(clk_i), .a_i(r2b_q), .b_i(rpb_w), .p_o(mc4));

  assign ct = bsc_pkg::sdiv((tlc2_q << 4) + (tlc2_q << 3) + tlc2_q, 6'd14);

  always_ff @(posedge clk_i) begin
    tlc1_q <= tlin_q;
    tlc2_q <= tlc1_q;
    tlc_q  <= tlc2_q;
    rpc1_q <= rpb_q;
    rpc2_q <= rpc1_q;
    rpc_q  <= rpc2_q;
    q1c_q  <= mc0;
    q2c_q  <= bsc_pkg::sdiv(mc0, 6'd6);
    q6c_q  <= mc1;
    q5sc_q <= mc2;
    r3c_q  <= mc3 + (bsc_pkg::sx16(coef.p9) << 16);
    r3bc_q <= bsc_pkg::sdiv(mc4, 6'd7);
    if ($signed(ct) < -64'sd8388608) begin
      tmpc_q <= 24'h800000;
      tflc_q <= 1'b1;
    end else if ($signed(ct) > 64'sd8388607) begin
      tmpc_q <= 24'h7FFFFF;
      tflc_q <= 1'b1;
    end else begin
      tmpc_q <= ct[23:0];
      tflc_q <= 1'b0;
    end
  end

  // level D
  typedef struct packed {
    logic [63:0] q6;
    logic [63:0] q5s;
    logic [63:0] r3b;
    logic [23:0] rp;
    logic [23:0] tmp;
    logic        tfl;
  } carry_d_t;

  logic [63:0] md0, md1, md2, md3, rpc_w;
  carry_d_t cd1_q, cd2_q, cd_q, cd_in;
  logic [63:0] q3d_q, q5d_q, q4sd_q, r4d_q;

  assign rpc_w = {40'd0, rpc_q};
  assign cd_in = '{q6: q6c_q, q5s: q5sc_q, r3b: r3bc_q, rp: rpc_q, tmp: tmpc_q, tfl: tflc_q};
  bsc_mul64 u_md0 (.clk_i(clk_i), .a_i(q2c_q), .b_i(tlc_q), .p_o(md0));
  bsc_mul64 u_md1 (.clk_i(clk_i), .a_i(bsc_pkg::sx8(coef.p7)), .b_i(q1c_q), .p_o(md1));
  bsc_mul64 u_md2 (.clk_i(clk_i), .a_i(bsc_pkg::sx8(coef.p3)), .b_i(q1c_q), .p_o(md2));
  bsc_mul64 u_md3 (.clk_i(clk_i), .a_i(r3c_q), .b_i(rpc_w), .p_o(md3));

  always_ff @(posedge clk_i) begin
    cd1_q  <= cd_in;
    cd2_q  <= cd1_q;
    cd_q   <= cd2_q;
    q3d_q  <= bsc_pkg::sdiv(md0, 6'd8);
    q5d_q  <= md1;
    q4sd_q <= md2;
    r4d_q  <= bsc_pkg::sdiv(md3, 6'd13);
  end

  // level E: offset and sensitivity sums, r5
  logic [63:0] me0, me1, me2, rpd_w;
  logic [63:0] q5e1_q, q5e2_q, q4se1_q, q4se2_q;
  carry_d_t ce1_q, ce2_q;
  logic [63:0] off_q, sens_q, r5e_q, r3be_q;
  logic [23:0] rpe_q, tmpe_q;
  logic        tfle_q;

  assign rpd_w = {40'd0, cd_q.rp};
  bsc_mul64 u_me0 (.clk_i(clk_i), .a_i(bsc_pkg::sx8(coef.p8)), .b_i(q3d_q), .p_o(me0));
  bsc_mul64 u_me1 (.clk_i(clk_i), .a_i(bsc_pkg::sx8(coef.p4)), .b_i(q3d_q), .p_o(me1));
  bsc_mul64 u_me2 (.clk_i(clk_i), .a_i(r4d_q), .b_i(rpd_w), .p_o(me2));

  always_ff @(posedge clk_i) begin
    ce1_q   <= cd_q;
    ce2_q   <= ce1_q;
    q5e1_q  <= q5d_q;
    q5e2_q  <= q5e1_q;
    q4se1_q <= q4sd_q;
    q4se2_q <= q4se1_q;
    off_q   <= (bsc_pkg::zx16(coef.p5) << 47) + bsc_pkg::sdiv(me0, 6'd5)
             + (q5e2_q << 4) + (ce2_q.q6 << 22);
    sens_q  <= ((bsc_pkg::sx16(coef.p1) - bsc_pkg::CoefBias) << 46)
             + bsc_pkg::sdiv(me1, 6'd5) + (q4se2_q << 2) + (ce2_q.q5s << 21);
    r5e_q   <= bsc_pkg::sdiv(me2, 6'd9);
    r3be_q  <= ce2_q.r3b;
    rpe_q   <= ce2_q.rp;
    tmpe_q  <= ce2_q.tmp;
    tfle_q  <= ce2_q.tfl;
  end

  // level F: final pressure sum
  typedef struct packed {
    logic [63:0] off;
    logic [63:0] r5;
    logic [63:0] r3b;
    logic [23:0] tmp;
    logic        tfl;
  } carry_f_t;

  logic [63:0] mf0;
  carry_f_t cf1_q, cf2_q, cf_in;
  logic [63:0] sum_q;
  logic [23:0] tmpf_q;
  logic        tflf_q;
  logic [63:0] s25;

  assign cf_in = '{off: off_q, r5: r5e_q, r3b: r3be_q, tmp: tmpe_q, tfl: tfle_q};
  bsc_mul64 u_mf0 (.clk_i(clk_i), .a_i(bsc_pkg::sdiv(sens_q, 6'd24)),
                   .b_i({40'd0, rpe_q}), .p_o(mf0));

  always_ff @(posedge clk_i) begin
    cf1_q  <= cf_in;
    cf2_q  <= cf1_q;
    sum_q  <= bsc_pkg::sdiv(cf2_q.off, 6'd2) + mf0 + cf2_q.r5 + cf2_q.r3b;
    tmpf_q <= cf2_q.tmp;
    tflf_q <= cf2_q.tfl;
  end

  // output register
  logic [23:0] tmp_out_q;
  logic [31:0] prs_out_q;
  logic        oor_q;

  assign s25 = (sum_q << 4) + (sum_q << 3) + sum_q;

  always_ff @(posedge clk_i) begin
    tmp_out_q <= tmpf_q;
    prs_out_q <= sum_q[63] ? 32'd0 : {8'd0, s25[63:40]};
    oor_q     <= tflf_q | sum_q[63];
  end

  assign done_o                 = vld_q[bsc_pkg::Lat-1];
  assign temperature_centideg_o = $signed(tmp_out_q);
  assign pressure_centipascal_o = prs_out_q;
  assign out_of_range_o         = oor_q;

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, bsc_pkg::Lat))
    else $error("result word without a start word");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> vld_q[0] == $past(start & ~busy))
    else $error("entry valid does not follow accepted word");

  a_press_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prs_out_q != 32'd0) |-> !$past(sum_q[63]))
    else $error("nonzero pressure from negative sum");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for baro_sensor_compensation: drives raw sample words,
// predicts each compensated word from the calibration bytes and checks every done_o strobe.
// Depends on bsc_pkg and the baro_sensor_compensation RTL.
module tb_top;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic signed [23:0] temp;
    logic [31:0]        press;
    logic               oor;
  } comp_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = bsc_pkg::CfgLow;
  logic [63:0]        cfg_wdata_i = '0;
  logic [23:0]        raw_temperature_i = '0;
  logic [23:0]        raw_pressure_i = '0;
  logic               done_o;
  logic signed [23:0] temperature_centideg_o;
  logic [31:0]        pressure_centipascal_o;
  logic               out_of_range_o;

  logic [63:0] cal_lo, cal_mid, cal_hi;
  comp_word_t  pending_words[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_enable = 1'b1;

  baro_sensor_compensation dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] cal_byte(int i);
    if (i < 8) return cal_lo[8*i +: 8];
    if (i < 16) return cal_mid[8*(i-8) +: 8];
    return cal_hi[8*(i-16) +: 8];
  endfunction

  function automatic logic [63:0] u16c(int i);
    return {48'd0, cal_byte(i+1), cal_byte(i)};
  endfunction

  function automatic logic [63:0] s16c(int i);
    logic [15:0] v;
    v = {cal_byte(i+1), cal_byte(i)};
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] s8c(int i);
    logic [7:0] v;
    v = cal_byte(i);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] div_pow2(logic [63:0] v, int sh);
    logic [63:0] mag;
    if (!v[63]) return v >> sh;
    mag = (~v + 64'd1) >> sh;
    return ~mag + 64'd1;
  endfunction

  function automatic comp_word_t compensate(logic [23:0] raw_t, logic [23:0] raw_p);
    comp_word_t w;
    logic [63:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic [63:0] d1, d2, d3, d4, d5, tlin, ct;
    logic [63:0] q1, q2, q3, q4, q5, q6, off, sens, r1, r2, r3, r4, r5, r6, sum;
    rt = {40'd0, raw_t};
    rp = {40'd0, raw_p};
    t1 = u16c(0); t2 = u16c(2); t3 = s8c(4);
    p1 = s16c(5); p2 = s16c(7); p3 = s8c(9); p4 = s8c(10);
    p5 = u16c(11); p6 = u16c(13); p7 = s8c(15); p8 = s8c(16);
    p9 = s16c(17); p10 = s8c(19); p11 = s8c(20);
    w.oor = 1'b0;
    d1 = rt - 64'd256 * t1;
    d2 = t2 * d1;
    d3 = d1 * d1;
    d4 = d3 * t3;
    d5 = d2 * 64'd262144 + d4;
    tlin = div_pow2(d5, 32);
    ct = div_pow2(tlin * 64'd25, 14);
    if ($signed(ct) < -64'sd8388608) begin
      w.temp = 24'h800000;
      w.oor = 1'b1;
    end else if ($signed(ct) > 64'sd8388607) begin
      w.temp = 24'h7FFFFF;
      w.oor = 1'b1;
    end else begin
      w.temp = ct[23:0];
    end
    q1 = tlin * tlin;
    q2 = div_pow2(q1, 6);
    q3 = div_pow2(q2 * tlin, 8);
    q4 = div_pow2(p8 * q3, 5);
    q5 = p7 * q1 * 64'd16;
    q6 = p6 * tlin * 64'd4194304;
    off = p5 * 64'd140737488355328 + q4 + q5 + q6;
    q2 = div_pow2(p4 * q3, 5);
    q4 = p3 * q1 * 64'd4;
    q5 = (p2 - 64'd16384) * tlin * 64'd2097152;
    sens = (p1 - 64'd16384) * 64'd70368744177664 + q2 + q4 + q5;
    r1 = div_pow2(sens, 24) * rp;
    r2 = p10 * tlin;
    r3 = r2 + 64'd65536 * p9;
    r4 = div_pow2(r3 * rp, 13);
    r5 = div_pow2(r4 * rp, 9);
    r6 = rp * rp;
    r2 = div_pow2(p11 * r6, 16);
    r3 = div_pow2(r2 * rp, 7);
    sum = div_pow2(off, 2) + r1 + r5 + r3;
    if (sum[63]) begin
      w.press = 32'd0;
      w.oor = 1'b1;
    end else begin
      w.press = (sum * 64'd25) >> 40;
    end
    return w;
  endfunction

  task automatic report_fail(string msg);
    if (mismatches < 10) $display("%0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    comp_word_t want;
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        report_fail("unexpected result word");
      end else begin
        want = pending_words.pop_front();
        if (temperature_centideg_o !== want.temp || pressure_centipascal_o !== want.press ||
            out_of_range_o !== want.oor)
          report_fail($sformatf("exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
                                want.temp, want.press, want.oor, temperature_centideg_o,
                                pressure_centipascal_o, out_of_range_o));
      end
    end
  end

  task automatic pause_cycle();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [23:0] rt, logic [23:0] rp);
    if (idle_enable)
      while ($urandom_range(99) < 23) pause_cycle();
    start <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i <= rp;
    do @(posedge clk_i); while (busy);
    pending_words.push_back(compensate(rt, rp));
  endtask

  task automatic drain();
    pause_cycle();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (bsc_pkg::Lat + 4) @(posedge clk_i);
  endtask

  task automatic write_cal(logic [1:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bsc_pkg::CfgLow:  cal_lo = data;
      bsc_pkg::CfgMid:  cal_mid = data;
      bsc_pkg::CfgHigh: cal_hi = {24'd0, data[39:0]};
      default: ;
    endcase
  endtask

  task automatic load_cal(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    drain();
    write_cal(bsc_pkg::CfgLow, lo);
    write_cal(bsc_pkg::CfgMid, mid);
    write_cal(bsc_pkg::CfgHigh, hi);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_calibration();
    cal_lo = '0; cal_mid = '0; cal_hi = '0;
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h800000, 24'h123456);
  endtask

  task automatic test_extremes();
    logic [23:0] pat[6] = '{24'd0, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'h800000, 24'd1};
    load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFF_FFFF_FFFF);
    foreach (pat[i]) send_sample(pat[i], pat[5-i]);
    load_cal(64'h7F64_0066_6711_6B70, 64'h80F9_7F03_E9A1_7F1E, 64'hFFFF_FF7F_D0FF_8012);
    foreach (pat[i]) send_sample(pat[i], pat[i]);
  endtask

  task automatic test_unused_index();
    load_cal(64'h1122_3344_5566_7788, 64'h99AA_BBCC_DDEE_F001, 64'hAB_CDEF_0123);
    write_cal(CfgUnused, rand64());
    write_cal(bsc_pkg::CfgHigh, 64'hFFFF_FF00_0000_0000 | 64'h12_3456_789A);
    send_sample(24'h6B7000, 24'h5A0000);
    send_sample(24'hFFFFFF, 24'd0);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_cal('0, '0, '0);
        1: load_cal('1, '1, '1);
        default: load_cal(rand64(), rand64(), rand64());
      endcase
      idle_enable = (phase != 3);
      for (int n = 0; n < 235; n++) begin
        if (phase == 5 && n == 100) drain();
        send_sample($urandom, $urandom);
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_calibration();
    test_extremes();
    test_unused_index();
    test_random();
    drain();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
